// ===== sv/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// token kinds, error codes, character codes and the keyword table of the
// source tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

  // result field widths
  localparam int KIND_W = 5;
  localparam int LINE_W = 16;
  localparam int COL_W  = 16;
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 16;
  localparam int ERR_W  = 2;

  // token kinds
  localparam logic [KIND_W-1:0] K_NUMBER   = 5'd0;
  localparam logic [KIND_W-1:0] K_STRING   = 5'd1;
  localparam logic [KIND_W-1:0] K_PLUS     = 5'd2;
  localparam logic [KIND_W-1:0] K_MINUS    = 5'd3;
  localparam logic [KIND_W-1:0] K_ASTERISK = 5'd4;
  localparam logic [KIND_W-1:0] K_SLASH    = 5'd5;
  localparam logic [KIND_W-1:0] K_SEMI     = 5'd6;
  localparam logic [KIND_W-1:0] K_COMMA    = 5'd7;
  localparam logic [KIND_W-1:0] K_COLON    = 5'd8;
  localparam logic [KIND_W-1:0] K_TICK     = 5'd9;
  localparam logic [KIND_W-1:0] K_IDENT    = 5'd10;
  localparam logic [KIND_W-1:0] K_ASSIGN   = 5'd11;
  localparam logic [KIND_W-1:0] K_EQUALS   = 5'd12;
  localparam logic [KIND_W-1:0] K_BANG     = 5'd13;
  localparam logic [KIND_W-1:0] K_LPAREN   = 5'd14;
  localparam logic [KIND_W-1:0] K_RPAREN   = 5'd15;
  localparam logic [KIND_W-1:0] K_LBRACE   = 5'd16;
  localparam logic [KIND_W-1:0] K_RBRACE   = 5'd17;
  localparam logic [KIND_W-1:0] K_KW_FIRST = 5'd18;
  localparam logic [KIND_W-1:0] K_EOF      = 5'd29;
  localparam logic [KIND_W-1:0] K_ERROR    = 5'd30;

  // error codes
  localparam logic [ERR_W-1:0] E_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] E_UNKNOWN   = 2'd1;
  localparam logic [ERR_W-1:0] E_UNTERM_STR = 2'd2;
  localparam logic [ERR_W-1:0] E_UNTERM_CMT = 2'd3;

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_TICK   = 8'h27;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  // keyword table, characters packed first-in-highest, right aligned
  localparam int KW_COUNT = 11;
  localparam int KW_BITS  = 48;
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_7072_6F63,  // proc
    48'h0000_0076_616C,  // val
    48'h0000_0000_6966,  // if
    48'h0000_656C_7365,  // else
    48'h0077_6869_6C65,  // while
    48'h7265_7475_726E,  // return
    48'h0000_0061_736D,  // asm
    48'h0000_6368_6172,  // char
    48'h0073_686F_7274,  // short
    48'h0000_0069_6E74,  // int
    48'h0000_7369_7A65   // size
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd3, 4'd2, 4'd4, 4'd5, 4'd6, 4'd3, 4'd4, 4'd5, 4'd3, 4'd4
  };

  // scanner state, one-hot
  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_NUMBER     = 10'b00_0000_0010,
    ST_IDENT      = 10'b00_0000_0100,
    ST_EQ         = 10'b00_0000_1000,
    ST_HASH       = 10'b00_0001_0000,
    ST_LINE       = 10'b00_0010_0000,
    ST_BLOCK      = 10'b00_0100_0000,
    ST_BLOCK_HASH = 10'b00_1000_0000,
    ST_STRING     = 10'b01_0000_0000,
    ST_STOP       = 10'b10_0000_0000
  } scan_mode_t;

  // one result record
  typedef struct packed {
    logic              last;
    logic [ERR_W-1:0]  err;
    logic [LEN_W-1:0]  len;
    logic [OFF_W-1:0]  off;
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] line;
    logic [KIND_W-1:0] kind;
  } tok_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

endpackage

`default_nettype wire

// ===== sv/source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer
// streaming lexer: source bytes in, token records out
// ----------------------------------------------------------------------------
// usage
//   in_*  : one source byte per request in in_tdata; a request with in_tlast
//           high ends the text (its data byte is ignored), flushes any pending
//           token and gives EOF, or an error if a string or block comment is
//           still open
//   out_* : one token per request; tdata carries line, column, offset and
//           length, tuser the kind and error code, tlast marks the final
//           token caused by one input request
//   a token enters the registered output queue when the byte that ends it is taken
//   throughput: one byte per cycle while in_tready is high; a byte that ends
//           a pending token and gives its own token produces two tokens into
//           the three-entry output queue, so in_tready drops after each such
//           byte even with out_tready held high
//   the scanner state and counters are registered, computed from the
//   registered state and the incoming byte; input is taken while at most
//   one token waits in the queue, so a stalled receiver backs up to in_tready
//   after an error or EOF every input is taken and dropped until rst_n
//   reset: synchronous, active low, clears the scanner to line 1, column 1,
//   offset 0 and empties the output queue
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer #(
  parameter int OFFSET_BITS   = 24,
  parameter int POSITION_BITS = 16,
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_byte
  input  wire logic        in_tlast,   // end_of_input
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [71:0] out_tdata,  // [15:0] line, [31:16] column,
                                       // [55:32] offset, [71:56] length
  output      logic [6:0]  out_tuser,  // [4:0] token kind, [6:5] error code
  output      logic        out_tlast   // last token of this input request
);

  import stok_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam int OW = OFFSET_BITS;
  localparam int KB = 8 * KEYWORD_CHARS;
  localparam logic [PW-1:0]    POS_MAX = '1;
  localparam logic [OW-1:0]    OFF_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // scanner state
  scan_mode_t       mode_r, mode_nxt;
  logic [PW-1:0]    line_r, line_nxt;
  logic [PW-1:0]    col_r, col_nxt;
  logic [OW-1:0]    off_r, off_nxt;
  logic [PW-1:0]    ps_line_r, ps_line_nxt;
  logic [PW-1:0]    ps_col_r, ps_col_nxt;
  logic [OW-1:0]    ps_off_r, ps_off_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [KB-1:0]    kwbuf_r, kwbuf_nxt;
  logic             kwovf_r, kwovf_nxt;

  // output queue, entry 0 drives the port
  tok_res_t   q_r [3];
  tok_res_t   q_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;

  logic       acc, pop;
  logic [7:0] c;
  logic       eoi;

  // saturating increments
  logic [PW-1:0]    line_inc, col_inc, col_inc2;
  logic [OW-1:0]    off_inc;
  logic [LEN_W-1:0] plen_inc;

  // flush result (pending token) and own result of this request
  logic       fa, fb, do_idle;
  tok_res_t   ra, rb, res0, res1;
  logic [1:0] nres;
  logic [KIND_W-1:0] ident_kind;
  logic [1:0] base;

  function automatic tok_res_t make_res(input logic [KIND_W-1:0] kind,
                                        input logic [PW-1:0] line,
                                        input logic [PW-1:0] col,
                                        input logic [OW-1:0] off,
                                        input logic [LEN_W-1:0] len,
                                        input logic [ERR_W-1:0] err);
    tok_res_t r;
    r.kind = kind;
    r.line = LINE_W'(line);
    r.col  = COL_W'(col);
    r.off  = OFF_W'(off);
    r.len  = len;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  assign c   = in_tdata;
  assign eoi = in_tlast;
  assign acc = in_tvalid && in_tready;
  assign pop = out_tvalid && out_tready;

  // room for two tokens
  assign in_tready = (cnt_r <= 2'd1);

  assign line_inc = (line_r == POS_MAX) ? line_r : line_r + PW'(1);
  assign col_inc  = (col_r == POS_MAX) ? col_r : col_r + PW'(1);
  assign col_inc2 = (col_r >= POS_MAX - PW'(1)) ? POS_MAX : col_r + PW'(2);
  assign off_inc  = (off_r == OFF_MAX) ? off_r : off_r + OW'(1);
  assign plen_inc = (plen_r == LEN_MAX) ? plen_r : plen_r + LEN_W'(1);

  // keyword match on the buffered identifier
  always_comb begin
    ident_kind = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!kwovf_r && (plen_r == LEN_W'(KW_LEN[k])) && (kwbuf_r == KB'(KW_TEXT[k])))
        ident_kind = K_KW_FIRST + KIND_W'(k);
    end
  end

  // next scanner state and the results of this request
  always_comb begin
    mode_nxt    = mode_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    off_nxt     = off_r;
    ps_line_nxt = ps_line_r;
    ps_col_nxt  = ps_col_r;
    ps_off_nxt  = ps_off_r;
    plen_nxt    = plen_r;
    kwbuf_nxt   = kwbuf_r;
    kwovf_nxt   = kwovf_r;
    fa          = 1'b0;
    fb          = 1'b0;
    do_idle     = 1'b0;
    ra          = '0;
    rb          = '0;

    // pending token that a terminating byte or end flushes
    case (mode_r)
      ST_NUMBER: ra = make_res(K_NUMBER, ps_line_r, ps_col_r, ps_off_r, plen_r, E_NONE);
      ST_IDENT:  ra = make_res(ident_kind, ps_line_r, ps_col_r, ps_off_r, plen_r, E_NONE);
      ST_EQ:     ra = make_res(K_ASSIGN, ps_line_r, ps_col_r, ps_off_r, LEN_W'(1), E_NONE);
      default:   ra = '0;
    endcase

    if (mode_r != ST_STOP) begin
      if (eoi) begin
        case (mode_r)
          ST_STRING: begin
            fb = 1'b1;
            rb = make_res(K_ERROR, ps_line_r, ps_col_r, ps_off_r, plen_r, E_UNTERM_STR);
          end
          ST_BLOCK, ST_BLOCK_HASH: begin
            fb = 1'b1;
            rb = make_res(K_ERROR, ps_line_r, ps_col_r, ps_off_r, '0, E_UNTERM_CMT);
          end
          default: begin
            fa = (mode_r == ST_NUMBER) || (mode_r == ST_IDENT) || (mode_r == ST_EQ);
            fb = 1'b1;
            rb = make_res(K_EOF, '0, '0, off_r, '0, E_NONE);
          end
        endcase
        mode_nxt = ST_STOP;
      end else begin
        case (mode_r)
          ST_NUMBER: begin
            if (is_digit(c)) begin
              plen_nxt = plen_inc;
              col_nxt  = col_inc;
            end else begin
              fa      = 1'b1;
              do_idle = 1'b1;
            end
          end
          ST_IDENT: begin
            if (is_digit(c) || is_alpha(c)) begin
              plen_nxt = plen_inc;
              if (!kwovf_r && (plen_inc <= LEN_W'(KEYWORD_CHARS)))
                kwbuf_nxt = {kwbuf_r[KB-9:0], c};
              else
                kwovf_nxt = 1'b1;
              col_nxt = col_inc;
            end else begin
              fa      = 1'b1;
              do_idle = 1'b1;
            end
          end
          ST_EQ: begin
            if (c == CH_EQ) begin
              fb       = 1'b1;
              rb       = make_res(K_EQUALS, ps_line_r, ps_col_r, ps_off_r, LEN_W'(2),
                                  E_NONE);
              col_nxt  = col_inc;
              mode_nxt = ST_IDLE;
            end else begin
              fa      = 1'b1;
              do_idle = 1'b1;
            end
          end
          ST_HASH: begin
            if (c == CH_HASH) begin
              mode_nxt = ST_BLOCK;
            end else if (c == CH_NL) begin
              line_nxt = line_inc;
              col_nxt  = PW'(1);
              mode_nxt = ST_IDLE;
            end else begin
              mode_nxt = ST_LINE;
            end
          end
          ST_LINE: begin
            // line comment bytes advance no column
            if (c == CH_NL) begin
              line_nxt = line_inc;
              col_nxt  = PW'(1);
              mode_nxt = ST_IDLE;
            end
          end
          ST_BLOCK: begin
            if (c == CH_HASH) begin
              mode_nxt = ST_BLOCK_HASH;
            end else if (c == CH_NL) begin
              line_nxt = line_inc;
              col_nxt  = PW'(1);
            end else begin
              col_nxt = col_inc;
            end
          end
          ST_BLOCK_HASH: begin
            // closing pair counts two columns; a lone hash counts one
            if (c == CH_HASH) begin
              col_nxt  = col_inc2;
              mode_nxt = ST_IDLE;
            end else begin
              mode_nxt = ST_BLOCK;
              if (c == CH_NL) begin
                line_nxt = line_inc;
                col_nxt  = PW'(1);
              end else begin
                col_nxt = col_inc2;
              end
            end
          end
          ST_STRING: begin
            if (c == CH_QUOTE) begin
              fb       = 1'b1;
              rb       = make_res(K_STRING, ps_line_r, ps_col_r, ps_off_r, plen_r, E_NONE);
              col_nxt  = col_inc;
              mode_nxt = ST_IDLE;
            end else begin
              plen_nxt = plen_inc;
              if (c == CH_NL) begin
                line_nxt = line_inc;
                col_nxt  = PW'(1);
              end else begin
                col_nxt = col_inc;
              end
            end
          end
          default: do_idle = 1'b1;
        endcase

        // byte seen with no token open
        if (do_idle) begin
          mode_nxt = ST_IDLE;
          case (c)
            CH_NL: begin
              line_nxt = line_inc;
              col_nxt  = PW'(1);
            end
            CH_TAB, CH_CR, CH_SPACE: col_nxt = col_inc;
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_SEMI, CH_COMMA, CH_COLON,
            CH_TICK, CH_BANG, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE: begin
              fb = 1'b1;
              rb = make_res(K_ERROR, line_r, col_r, off_r, LEN_W'(1), E_NONE);
              case (c)
                CH_PLUS:   rb.kind = K_PLUS;
                CH_MINUS:  rb.kind = K_MINUS;
                CH_STAR:   rb.kind = K_ASTERISK;
                CH_SLASH:  rb.kind = K_SLASH;
                CH_SEMI:   rb.kind = K_SEMI;
                CH_COMMA:  rb.kind = K_COMMA;
                CH_COLON:  rb.kind = K_COLON;
                CH_TICK:   rb.kind = K_TICK;
                CH_BANG:   rb.kind = K_BANG;
                CH_LPAREN: rb.kind = K_LPAREN;
                CH_RPAREN: rb.kind = K_RPAREN;
                CH_LBRACE: rb.kind = K_LBRACE;
                default:   rb.kind = K_RBRACE;
              endcase
              col_nxt = col_inc;
            end
            default: begin
              // '=', '#', '"', digits and letters open a pending token
              ps_line_nxt = line_r;
              ps_col_nxt  = col_r;
              ps_off_nxt  = off_r;
              plen_nxt    = '0;
              kwbuf_nxt   = '0;
              kwovf_nxt   = 1'b0;
              if (c == CH_EQ) begin
                col_nxt  = col_inc;
                mode_nxt = ST_EQ;
              end else if (c == CH_HASH) begin
                mode_nxt = ST_HASH;
              end else if (c == CH_QUOTE) begin
                col_nxt  = col_inc;
                mode_nxt = ST_STRING;
              end else if (is_digit(c)) begin
                plen_nxt = LEN_W'(1);
                col_nxt  = col_inc;
                mode_nxt = ST_NUMBER;
              end else if (is_alpha(c)) begin
                plen_nxt  = LEN_W'(1);
                kwbuf_nxt = KB'(c);
                col_nxt   = col_inc;
                mode_nxt  = ST_IDENT;
              end else begin
                fb       = 1'b1;
                rb       = make_res(K_ERROR, line_r, col_r, off_r, LEN_W'(1), E_UNKNOWN);
                mode_nxt = ST_STOP;
              end
            end
          endcase
        end

        off_nxt = off_inc;
      end
    end
  end

  // order the results and mark the last one
  always_comb begin
    res0 = fa ? ra : rb;
    res1 = rb;
    nres = {1'b0, fa} + {1'b0, fb};
    if (nres == 2'd2)
      res1.last = 1'b1;
    else
      res0.last = 1'b1;
  end

  // queue shift and append
  always_comb begin
    for (int i = 0; i < 3; i++)
      q_nxt[i] = q_r[i];
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
    end
    base = cnt_r - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      if (acc && (nres != 2'd0) && (2'(i) == base))
        q_nxt[i] = res0;
      if (acc && (nres == 2'd2) && (2'(i) == base + 2'd1))
        q_nxt[i] = res1;
    end
    cnt_nxt = base + (acc ? nres : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ST_IDLE;
      line_r    <= PW'(1);
      col_r     <= PW'(1);
      off_r     <= '0;
      ps_line_r <= '0;
      ps_col_r  <= '0;
      ps_off_r  <= '0;
      plen_r    <= '0;
      kwbuf_r   <= '0;
      kwovf_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        mode_r    <= mode_nxt;
        line_r    <= line_nxt;
        col_r     <= col_nxt;
        off_r     <= off_nxt;
        ps_line_r <= ps_line_nxt;
        ps_col_r  <= ps_col_nxt;
        ps_off_r  <= ps_off_nxt;
        plen_r    <= plen_nxt;
        kwbuf_r   <= kwbuf_nxt;
        kwovf_r   <= kwovf_nxt;
      end
    end
  end

  // queue payload needs no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      q_r[i] <= q_nxt[i];
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {q_r[0].len, q_r[0].off, q_r[0].col, q_r[0].line};
  assign out_tuser  = {q_r[0].err, q_r[0].kind};
  assign out_tlast  = q_r[0].last;

  // once stopped, no new tokens enter the queue
  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == ST_STOP) |=> (cnt_r <= $past(cnt_r)))
    else $error("token produced after stop");

  // an end request always stops the scanner
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (mode_r == ST_STOP))
    else $error("end of input did not stop scanner");

  // line and column counters start at one and saturate, never wrap to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != '0) && (col_r != '0))
    else $error("line or column counter reached zero");

  // an accepted request never overfills the queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (cnt_r <= 2'd3) && ($past(cnt_r) <= 2'd1))
    else $error("output queue overflow");

endmodule

`default_nettype wire

// ===== bench/source_tokenizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_tokenizer_tb
// self-checking bench for the streaming source tokenizer: source bytes are
// offered on in_*, a scoreboard lexes each accepted byte on its own and
// compares every token leaving out_* field by field, in order
// ----------------------------------------------------------------------------

module source_tokenizer_tb;
  import stok_pkg::*;

  localparam int KW_CHARS     = 6;      // longest name still checked for a keyword
  localparam int RANDOM_BYTES = 1700;   // bytes offered before the closing stretches
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int QUIET_LIMIT  = 4000;   // cycles without any request before giving up
  localparam int TAIL_CYCLES  = 20;     // settle time after the last token
  localparam int MAX_REPORTS  = 50;     // keep the log short on a badly broken build

  // --------------------------------------------------------------------------
  // scoreboard: own lexer state, the tokens still owed by the block, checking
  // --------------------------------------------------------------------------
  class token_checker;
    tok_res_t          tokens_due[$];
    int                mismatches;
    int                made;             // tokens caused by the current byte
    scan_mode_t        mode;
    logic [LINE_W-1:0] line_no;
    logic [COL_W-1:0]  col_no;
    logic [OFF_W-1:0]  offs;
    logic [LINE_W-1:0] tok_line;
    logic [COL_W-1:0]  tok_col;
    logic [OFF_W-1:0]  tok_off;
    logic [LEN_W-1:0]  tok_len;
    logic [47:0]       kw_buf;
    logic              kw_spill;

    function new();
      mismatches = 0;
      mode       = ST_IDLE;
      line_no    = 16'd1;
      col_no     = 16'd1;
      offs       = '0;
      tok_line   = '0;
      tok_col    = '0;
      tok_off    = '0;
      tok_len    = '0;
      kw_buf     = '0;
      kw_spill   = 1'b0;
    endfunction

    function string kw_name(int k);
      case (k)
        0:       return "proc";
        1:       return "val";
        2:       return "if";
        3:       return "else";
        4:       return "while";
        5:       return "return";
        6:       return "asm";
        7:       return "char";
        8:       return "short";
        9:       return "int";
        default: return "size";
      endcase
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function logic [15:0] sat16(logic [15:0] v);
      return (&v) ? v : v + 16'd1;
    endfunction

    function logic [23:0] sat24(logic [23:0] v);
      return (&v) ? v : v + 24'd1;
    endfunction

    function logic digit_char(logic [7:0] c);
      return (c >= "0") && (c <= "9");
    endfunction

    function logic letter_char(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function void emit(logic [KIND_W-1:0] kind, logic [LINE_W-1:0] ln,
                       logic [COL_W-1:0] cl, logic [OFF_W-1:0] of,
                       logic [LEN_W-1:0] len, logic [ERR_W-1:0] err);
      tok_res_t t;
      t.kind = kind;
      t.line = ln;
      t.col  = cl;
      t.off  = of;
      t.len  = len;
      t.err  = err;
      t.last = 1'b0;
      tokens_due.push_back(t);
      made++;
    endfunction

    function void mark();
      tok_line = line_no;
      tok_col  = col_no;
      tok_off  = offs;
      tok_len  = '0;
      kw_buf   = '0;
      kw_spill = 1'b0;
    endfunction

    function void step_col();
      col_no = sat16(col_no);
    endfunction

    function void next_line();
      line_no = sat16(line_no);
      col_no  = 16'd1;
    endfunction

    function void grow_ident(logic [7:0] c);
      tok_len = sat16(tok_len);
      if (!kw_spill && tok_len <= KW_CHARS) kw_buf = {kw_buf[39:0], c};
      else kw_spill = 1'b1;
      step_col();
    endfunction

    function logic [KIND_W-1:0] word_kind();
      string             s;
      logic [47:0]       pk;
      logic [KIND_W-1:0] kk;
      if (kw_spill) return K_IDENT;
      for (int k = 0; k < 11; k++) begin
        s = kw_name(k);
        if (s.len() == tok_len) begin
          pk = '0;
          for (int j = 0; j < s.len(); j++) pk = {pk[39:0], s[j]};
          if (pk == kw_buf) begin
            kk = K_KW_FIRST + KIND_W'(k);
            return kk;
          end
        end
      end
      return K_IDENT;
    endfunction

    function void flush_pending();
      case (mode)
        ST_NUMBER: emit(K_NUMBER, tok_line, tok_col, tok_off, tok_len, E_NONE);
        ST_IDENT:  emit(word_kind(), tok_line, tok_col, tok_off, tok_len, E_NONE);
        ST_EQ:     emit(K_ASSIGN, tok_line, tok_col, tok_off, 16'd1, E_NONE);
        default: ;
      endcase
      mode = ST_IDLE;
    endfunction

    function void idle_char(logic [7:0] c);
      logic [KIND_W-1:0] kind;
      logic              single;
      single = 1'b1;
      kind   = K_PLUS;
      case (c)
        CH_NL: begin
          next_line();
          single = 1'b0;
        end
        CH_TAB, CH_CR, CH_SPACE: begin
          step_col();
          single = 1'b0;
        end
        CH_PLUS:   kind = K_PLUS;
        CH_MINUS:  kind = K_MINUS;
        CH_STAR:   kind = K_ASTERISK;
        CH_SLASH:  kind = K_SLASH;
        CH_SEMI:   kind = K_SEMI;
        CH_COMMA:  kind = K_COMMA;
        CH_COLON:  kind = K_COLON;
        CH_TICK:   kind = K_TICK;
        CH_BANG:   kind = K_BANG;
        CH_LPAREN: kind = K_LPAREN;
        CH_RPAREN: kind = K_RPAREN;
        CH_LBRACE: kind = K_LBRACE;
        CH_RBRACE: kind = K_RBRACE;
        CH_EQ: begin
          mark();
          step_col();
          mode   = ST_EQ;
          single = 1'b0;
        end
        CH_HASH: begin
          mark();
          mode   = ST_HASH;
          single = 1'b0;
        end
        CH_QUOTE: begin
          mark();
          step_col();
          mode   = ST_STRING;
          single = 1'b0;
        end
        default: begin
          single = 1'b0;
          if (digit_char(c)) begin
            mark();
            tok_len = 16'd1;
            step_col();
            mode = ST_NUMBER;
          end else if (letter_char(c)) begin
            mark();
            grow_ident(c);
            mode = ST_IDENT;
          end else begin
            emit(K_ERROR, line_no, col_no, offs, 16'd1, E_UNKNOWN);
            mode = ST_STOP;
          end
        end
      endcase
      if (single) begin
        emit(kind, line_no, col_no, offs, 16'd1, E_NONE);
        step_col();
      end
    endfunction

    function void block_char(logic [7:0] c);
      if (c == CH_HASH) mode = ST_BLOCK_HASH;
      else if (c == CH_NL) next_line();
      else step_col();
    endfunction

    // one accepted input request
    function void take_byte(logic [7:0] c, logic eoi);
      tok_res_t t;
      made = 0;
      if (mode == ST_STOP) return;
      if (eoi) begin
        if (mode == ST_STRING)
          emit(K_ERROR, tok_line, tok_col, tok_off, tok_len, E_UNTERM_STR);
        else if (mode == ST_BLOCK || mode == ST_BLOCK_HASH)
          emit(K_ERROR, tok_line, tok_col, tok_off, 16'd0, E_UNTERM_CMT);
        else begin
          flush_pending();
          emit(K_EOF, 16'd0, 16'd0, offs, 16'd0, E_NONE);
        end
        mode = ST_STOP;
      end else begin
        case (mode)
          ST_NUMBER: begin
            if (digit_char(c)) begin
              tok_len = sat16(tok_len);
              step_col();
            end else begin
              flush_pending();
              idle_char(c);
            end
          end
          ST_IDENT: begin
            if (letter_char(c) || digit_char(c)) grow_ident(c);
            else begin
              flush_pending();
              idle_char(c);
            end
          end
          ST_EQ: begin
            if (c == CH_EQ) begin
              emit(K_EQUALS, tok_line, tok_col, tok_off, 16'd2, E_NONE);
              step_col();
              mode = ST_IDLE;
            end else begin
              flush_pending();
              idle_char(c);
            end
          end
          ST_HASH: begin
            if (c == CH_HASH) mode = ST_BLOCK;
            else if (c == CH_NL) begin
              next_line();
              mode = ST_IDLE;
            end else mode = ST_LINE;
          end
          ST_LINE: begin
            if (c == CH_NL) begin
              next_line();
              mode = ST_IDLE;
            end
          end
          ST_BLOCK: block_char(c);
          ST_BLOCK_HASH: begin
            if (c == CH_HASH) begin
              step_col();
              step_col();
              mode = ST_IDLE;
            end else begin
              step_col();
              mode = ST_BLOCK;
              block_char(c);
            end
          end
          ST_STRING: begin
            if (c == CH_QUOTE) begin
              emit(K_STRING, tok_line, tok_col, tok_off, tok_len, E_NONE);
              step_col();
              mode = ST_IDLE;
            end else begin
              tok_len = sat16(tok_len);
              if (c == CH_NL) next_line();
              else step_col();
            end
          end
          default: idle_char(c);
        endcase
        offs = sat24(offs);
      end
      if (made > 0) begin
        t = tokens_due.pop_back();
        t.last = 1'b1;
        tokens_due.push_back(t);
      end
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        mismatches++;
      end
    endfunction

    // one accepted result request
    function void match_token(tok_res_t got);
      tok_res_t want;
      if (tokens_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected token, kind %0d line %0d col %0d off %0d len %0d err %0d",
                   $time, got.kind, got.line, got.col, got.off, got.len, got.err);
        mismatches++;
        return;
      end
      want = tokens_due.pop_front();
      compare("kind", 32'(want.kind), 32'(got.kind));
      compare("line", 32'(want.line), 32'(got.line));
      compare("column", 32'(want.col), 32'(got.col));
      compare("offset", 32'(want.off), 32'(got.off));
      compare("length", 32'(want.len), 32'(got.len));
      compare("error code", 32'(want.err), 32'(got.err));
      compare("last flag", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports, all known from time zero
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] char_byte
  logic        in_tlast   = 1'b0;    // end_of_input
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;            // [15:0] line, [31:16] column,
                                     // [55:32] offset, [71:56] length
  logic [6:0]  out_tuser;            // [4:0] token kind, [6:5] error code
  logic        out_tlast;            // last token of one input request

  token_checker sb;
  int           bytes_taken = 0;
  logic         calm        = 1'b0;  // no idling on either side while set
  logic         hold_req    = 1'b0;  // asks the receiver for its long hold-off
  logic         hold_done   = 1'b0;

  source_tokenizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // offer one byte, with an occasional idle burst first; the scoreboard hears
  // about it at the edge where the request completes
  task automatic send_item(input logic [7:0] c, input logic e = 1'b0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= e;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(c, e);
    bytes_taken++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] any_byte_but(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    while (r == a || r == b) r = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // stop offering and wait until every owed token has left the block
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // bring the scanner back out of a string or comment, going by our own state
  task automatic recover();
    case (sb.mode)
      ST_STRING:     send_item(CH_QUOTE);
      ST_BLOCK: begin
        send_item(CH_HASH);
        send_item(CH_HASH);
      end
      ST_BLOCK_HASH: send_item(CH_HASH);
      ST_HASH,
      ST_LINE:       send_item(CH_NL);
      default: ;
    endcase
  endtask

  // one well-formed piece of source with random content
  task automatic send_phrase();
    string      w;
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: begin
        w = sb.kw_name($urandom_range(0, 10));
        case ($urandom_range(0, 3))
          0: send_text(w);                               // keyword as it is
          1: begin                                       // keyword with a tail
            send_text(w);
            send_item(pick("abcxyzAZ_019"));
          end
          2: send_text(w.substr(0, w.len() - 2));        // keyword cut short
          default: begin                                 // free identifier, some long
            send_item(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
            repeat ($urandom_range(0, 8))
              send_item(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789"));
          end
        endcase
      end
      2: repeat ($urandom_range(1, 5)) send_item(pick("0123456789"));
      3, 9: send_item(pick("+-*/;,:'!(){}"));
      4: begin                                           // assign, equals, equals then assign
        send_item(CH_EQ);
        if ($urandom_range(0, 1)) send_item(CH_EQ);
        if ($urandom_range(0, 3) == 0) send_item(CH_EQ);
      end
      5: repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0) send_item(CH_CR);
        else send_item(pick(" \t\n"));
      end
      6: begin                                           // string, any byte but a quote inside
        send_item(CH_QUOTE);
        repeat ($urandom_range(0, 8)) send_item(any_byte_but(CH_QUOTE, CH_QUOTE));
        send_item(CH_QUOTE);
      end
      7: begin                                           // line comment, maybe empty
        send_item(CH_HASH);
        if ($urandom_range(0, 3) != 0) begin
          send_item(any_byte_but(CH_HASH, CH_NL));
          repeat ($urandom_range(0, 6)) send_item(any_byte_but(CH_NL, CH_NL));
        end
        send_item(CH_NL);
      end
      default: begin                                     // block comment, lone hashes inside
        send_item(CH_HASH);
        send_item(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
          b = any_byte_but(CH_HASH, CH_HASH);
          if ($urandom_range(0, 4) == 0) send_item(CH_HASH);
          send_item(b);
        end
        send_item(CH_HASH);
        send_item(CH_HASH);
      end
    endcase
  endtask

  // short runs of legal start characters with no structure, then a way back
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_item(pick("+-*/;,:'!(){}=#\" \tab09_"));
    recover();
  endtask

  function automatic logic [7:0] unknown_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'($urandom_range(128, 255));
      2:       return pick("$%&.<>?@[\\]^`|~");
      default: return 8'($urandom_range(1, 8));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operator, identifier, number, equals against assign,
    // a byte that closes one token and makes another, a string holding the
    // byte extremes and a newline, an empty line comment, a block comment
    // with a lone hash inside
    send_text("{(a9==12)}!+-*/;,:'=");
    send_item(CH_QUOTE);
    send_item(8'h00);
    send_item(8'hFF);
    send_item(CH_NL);
    send_item(CH_QUOTE);
    send_text("\t#\n##x#");
    send_item(CH_CR);
    send_text("##");

    // sender pauses until the block has given everything back
    drain();

    // random source; the receiver starts with its long hold-off so the output
    // queue fills and in_tready drops while bytes keep being offered
    hold_req = 1'b1;
    while (bytes_taken < RANDOM_BYTES) begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      if ($urandom_range(0, 99) < 85) send_phrase();
      else send_noise();
    end

    // closing stretch, no idling: a string, a token right after it, a few
    // newlines and a last pair of tokens
    calm = 1'b1;
    recover();
    send_item(CH_QUOTE);
    repeat (20) send_item(any_byte_but(CH_QUOTE, CH_NL));
    send_item(CH_QUOTE);
    send_item(pick("abcxyz_"));
    repeat (4) send_item(CH_NL);
    send_text("y;");

    // the run ends one way, picked at random: plain end, end flushing a
    // pending token, end inside a string, end inside a block comment, or an
    // unknown byte
    case ($urandom_range(0, 4))
      0: send_item(8'($urandom_range(0, 255)), 1'b1);
      1: begin
        case ($urandom_range(0, 2))
          0:       send_item(pick("abcxyz_"));
          1:       send_item(pick("0123456789"));
          default: send_item(CH_EQ);
        endcase
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        send_item(CH_QUOTE);
        repeat ($urandom_range(0, 5)) send_item(any_byte_but(CH_QUOTE, CH_QUOTE));
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      3: begin
        send_item(CH_HASH);
        send_item(CH_HASH);
        repeat ($urandom_range(0, 5)) send_item(any_byte_but(CH_HASH, CH_HASH));
        if ($urandom_range(0, 1)) send_item(CH_HASH);
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        if ($urandom_range(0, 1)) send_item(pick("abcxyz_0"));
        send_item(unknown_byte());
      end
    endcase

    // the block is stopped now, these are taken and dropped
    repeat (5) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_item(8'($urandom_range(0, 255)), 1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: random idle bursts, one long hold-off when asked
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // result monitor: unpack each accepted token and hand it to the scoreboard
  always @(posedge clk) begin : token_mon
    tok_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.line = out_tdata[15:0];
      got.col  = out_tdata[31:16];
      got.off  = out_tdata[55:32];
      got.len  = out_tdata[71:56];
      got.kind = out_tuser[4:0];
      got.err  = out_tuser[6:5];
      got.last = out_tlast;
      sb.match_token(got);
    end
  end

  // watchdog: too long without a request on either side means a hang
  always @(posedge clk) begin : hang_watch
    int quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
